// ----- design/cdq_pkg.sv -----
// Shared types, constants and index helpers for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SHOW       = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SHOW
  } state_e;

  function automatic idx_t idx_next(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t idx_prev(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

endpackage

// ----- design/cdq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/circular_deque.sv -----
// Top level of the double-ended queue: control sequencer, output register and store.
//
//   channel  | dir | tdata         | tuser              | tlast
//   s_axis   | in  | value [31:0]  | func [2:0]         | -
//   m_axis   | out | data [31:0]   | status [1:0]       | last result of the item
//
// One item at a time. Push: accept, then store write. Pop: accept, store read,
// result. Show: accept, then one result per listed element, each read in turn
// through the single read port of the store. Undefined func codes: accept, no result.
// Reset empties the queue at once; the store itself is not cleared.
// A stalled output holds the sequencer; a new item is taken while a result waits.
`timescale 1ns / 1ps

module circular_deque (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast
);

  cdq_pkg::state_e  state_q, state_d;
  cdq_pkg::func_e   func_q, func_d;
  cdq_pkg::data_t   value_q, value_d;
  cdq_pkg::idx_t    head_q, head_d;
  cdq_pkg::idx_t    tail_q, tail_d;
  cdq_pkg::idx_t    walk_q, walk_d;
  logic             holds_q, holds_d;

  logic             out_valid_q, out_valid_d;
  cdq_pkg::status_e out_status_q, out_status_d;
  cdq_pkg::data_t   out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             full;
  logic             emit;
  cdq_pkg::status_e res_status;
  cdq_pkg::data_t   res_data;
  logic             res_last;

  logic             ram_we;
  cdq_pkg::idx_t    ram_waddr;
  logic             ram_re;
  cdq_pkg::idx_t    ram_raddr;
  cdq_pkg::data_t   ram_rdata;

  assign out_free = !out_valid_q || m_axis_tready;
  assign full     = holds_q && (head_q == cdq_pkg::idx_next(tail_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      holds_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      holds_q     <= holds_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    value_q      <= value_d;
    walk_q       <= walk_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d       = state_q;
    func_d        = func_q;
    value_d       = value_q;
    head_d        = head_q;
    tail_d        = tail_q;
    holds_d       = holds_q;
    walk_d        = walk_q;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    res_status    = cdq_pkg::STAT_OK;
    res_data      = '0;
    res_last      = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_q)
      cdq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          func_d  = cdq_pkg::func_e'(s_axis_tuser);
          value_d = s_axis_tdata;
          state_d = cdq_pkg::S_EXEC;
        end
      end
      cdq_pkg::S_EXEC: begin
        case (func_q) inside
          cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_BACK: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = cdq_pkg::S_IDLE;
              if (full) begin
                res_status = cdq_pkg::STAT_OVERFLOW;
              end else begin
                ram_we  = 1'b1;
                holds_d = 1'b1;
                if (!holds_q) begin
                  head_d    = '0;
                  tail_d    = '0;
                  ram_waddr = '0;
                end else if (func_q == cdq_pkg::FN_PUSH_FRONT) begin
                  head_d    = cdq_pkg::idx_prev(head_q);
                  ram_waddr = cdq_pkg::idx_prev(head_q);
                end else begin
                  tail_d    = cdq_pkg::idx_next(tail_q);
                  ram_waddr = cdq_pkg::idx_next(tail_q);
                end
              end
            end
          end
          cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_BACK: begin
            if (!holds_q) begin
              if (out_free) begin
                emit       = 1'b1;
                res_status = cdq_pkg::STAT_UNDERFLOW;
                state_d    = cdq_pkg::S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = (func_q == cdq_pkg::FN_POP_FRONT) ? head_q : tail_q;
              state_d   = cdq_pkg::S_POP;
              if (head_q == tail_q) begin
                head_d  = '0;
                tail_d  = '0;
                holds_d = 1'b0;
              end else if (func_q == cdq_pkg::FN_POP_FRONT) begin
                head_d = cdq_pkg::idx_next(head_q);
              end else begin
                tail_d = cdq_pkg::idx_prev(tail_q);
              end
            end
          end
          cdq_pkg::FN_SHOW: begin
            if (!holds_q) begin
              if (out_free) begin
                emit       = 1'b1;
                res_status = cdq_pkg::STAT_EMPTY;
                state_d    = cdq_pkg::S_IDLE;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              walk_d    = head_q;
              state_d   = cdq_pkg::S_SHOW;
            end
          end
          default: begin
            state_d = cdq_pkg::S_IDLE;
          end
        endcase
      end
      cdq_pkg::S_POP: begin
        if (out_free) begin
          emit     = 1'b1;
          res_data = ram_rdata;
          state_d  = cdq_pkg::S_IDLE;
        end
      end
      cdq_pkg::S_SHOW: begin
        if (out_free) begin
          emit     = 1'b1;
          res_data = ram_rdata;
          res_last = (walk_q == tail_q);
          if (walk_q == tail_q) begin
            state_d = cdq_pkg::S_IDLE;
          end else begin
            walk_d    = cdq_pkg::idx_next(walk_q);
            ram_re    = 1'b1;
            ram_raddr = cdq_pkg::idx_next(walk_q);
          end
        end
      end
      default: begin
        state_d = cdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_data_d   = res_data;
      out_last_d   = res_last;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- design/cdq_checker.sv -----
// Port-level checks on the circular deque and their binding to the top level.
`timescale 1ns / 1ps

module cdq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cdq_pkg::STAT_OK) |-> m_axis_tlast)
    else $error("error status without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cdq_pkg::STAT_OK) |-> (m_axis_tdata == '0))
    else $error("error status with nonzero data");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second input transfer while an item is in work");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/tb_circular_deque.sv -----
// Self-checking stream testbench for the circular double-ended queue.
`timescale 1ns / 1ps

class deque_scoreboard;

  typedef struct {
    cdq_pkg::status_e status;
    cdq_pkg::data_t   data;
    logic             last;
  } deque_result_t;

  cdq_pkg::data_t slots [cdq_pkg::DEPTH];
  cdq_pkg::idx_t  head;
  cdq_pkg::idx_t  tail;
  bit             holds;
  deque_result_t  pending [$];
  int             mismatches;
  int             results_seen;
  int             requests;
  int             status_count [4];

  function new();
    head  = '0;
    tail  = '0;
    holds = 1'b0;
  endfunction

  function cdq_pkg::idx_t wrap_inc(cdq_pkg::idx_t i);
    return cdq_pkg::idx_t'((int'(i) + 1) % cdq_pkg::DEPTH);
  endfunction

  function cdq_pkg::idx_t wrap_dec(cdq_pkg::idx_t i);
    return cdq_pkg::idx_t'((int'(i) + cdq_pkg::DEPTH - 1) % cdq_pkg::DEPTH);
  endfunction

  function void add_result(cdq_pkg::status_e status, cdq_pkg::data_t data, logic last);
    deque_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    pending.push_back(r);
    status_count[status]++;
  endfunction

  function void note_request(logic [2:0] code, cdq_pkg::data_t value);
    bit             full;
    cdq_pkg::idx_t  t;
    int             n;
    cdq_pkg::data_t popped;
    full = holds && (head == wrap_inc(tail));
    case (code)
      cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_BACK: begin
        requests++;
        if (full) begin
          add_result(cdq_pkg::STAT_OVERFLOW, '0, 1'b1);
        end else begin
          if (!holds) begin
            head     = '0;
            tail     = '0;
            slots[0] = value;
            holds    = 1'b1;
          end else if (code == cdq_pkg::FN_PUSH_FRONT) begin
            head        = wrap_dec(head);
            slots[head] = value;
          end else begin
            tail        = wrap_inc(tail);
            slots[tail] = value;
          end
          add_result(cdq_pkg::STAT_OK, '0, 1'b1);
        end
      end
      cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_BACK: begin
        requests++;
        if (!holds) begin
          add_result(cdq_pkg::STAT_UNDERFLOW, '0, 1'b1);
        end else begin
          popped = (code == cdq_pkg::FN_POP_FRONT) ? slots[head] : slots[tail];
          if (head == tail) begin
            head  = '0;
            tail  = '0;
            holds = 1'b0;
          end else if (code == cdq_pkg::FN_POP_FRONT) begin
            head = wrap_inc(head);
          end else begin
            tail = wrap_dec(tail);
          end
          add_result(cdq_pkg::STAT_OK, popped, 1'b1);
        end
      end
      cdq_pkg::FN_SHOW: begin
        requests++;
        if (!holds) begin
          add_result(cdq_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          t = head;
          n = 0;
          while (n < cdq_pkg::DEPTH - 1 && t != tail) begin
            add_result(cdq_pkg::STAT_OK, slots[t], 1'b0);
            n++;
            t = wrap_inc(t);
          end
          add_result(cdq_pkg::STAT_OK, slots[t], 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task log_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task check_result(logic [1:0] status, cdq_pkg::data_t data, logic last);
    deque_result_t want;
    results_seen++;
    if (pending.size() == 0) begin
      log_mismatch($sformatf("unexpected transfer status=%0d data=%h last=%b",
                             status, data, last));
    end else begin
      want = pending.pop_front();
      if (status !== want.status)
        log_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (data !== want.data)
        log_mismatch($sformatf("data %h, want %h", data, want.data));
      if (last !== want.last)
        log_mismatch($sformatf("last %b, want %b", last, want.last));
    end
  endtask

endclass

module tb_circular_deque;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 300_000;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 150;
  localparam int ITEM_TARGET  = 350;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  deque_scoreboard sb;
  int src_idle_pct;
  int sink_stall_pct;
  int items_sent;
  int hold_left;
  bit hold_req;

  circular_deque dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic cdq_pkg::data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic [2:0] code, cdq_pkg::data_t value);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(code, value);
    if (code <= cdq_pkg::FN_SHOW) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_phase(int target);
    int kind;
    int len;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(4, 20);
      if (kind < 4) begin
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) send_item(cdq_pkg::FN_SHOW, pick_value());
          else send_item($urandom_range(0, 1) ? cdq_pkg::FN_PUSH_BACK
                                              : cdq_pkg::FN_PUSH_FRONT,
                         pick_value());
        end
      end else if (kind < 8) begin
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) send_item(cdq_pkg::FN_SHOW, pick_value());
          else send_item($urandom_range(0, 1) ? cdq_pkg::FN_POP_BACK
                                              : cdq_pkg::FN_POP_FRONT,
                         pick_value());
        end
      end else if (kind == 8) begin
        repeat (8) send_item(3'($urandom_range(0, 7)), pick_value());
      end else begin
        send_item(cdq_pkg::FN_SHOW, pick_value());
      end
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    sb             = new();
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rst_ni) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results outstanding", sb.pending.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(cdq_pkg::FN_POP_FRONT, 32'h1234_5678);
    send_item(cdq_pkg::FN_POP_BACK, '1);
    send_item(cdq_pkg::FN_SHOW, '0);
    send_item(cdq_pkg::FN_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(cdq_pkg::FN_SHOW, '0);
    send_item(cdq_pkg::FN_POP_BACK, '0);
    send_item(cdq_pkg::FN_PUSH_BACK, 32'h8000_0000);
    send_item(cdq_pkg::FN_PUSH_FRONT, '0);
    send_item(cdq_pkg::FN_PUSH_BACK, '1);
    send_item(cdq_pkg::FN_PUSH_FRONT, 32'hA5A5_5A5A);
    send_item(cdq_pkg::FN_SHOW, '0);
    send_item(cdq_pkg::FN_POP_FRONT, '0);
    send_item(cdq_pkg::FN_POP_BACK, '0);
    send_item(3'd5, 32'hFFFF_FFFF);
    send_item(3'd6, 32'h0000_0001);
    send_item(3'd7, 32'h8000_0000);
    send_item(cdq_pkg::FN_POP_FRONT, '0);
    send_item(cdq_pkg::FN_POP_FRONT, '0);
    send_item(cdq_pkg::FN_SHOW, '0);

    // long sink hold while pushes keep coming: the block must back up
    hold_req = 1'b1;
    repeat (20) send_item($urandom_range(0, 1) ? cdq_pkg::FN_PUSH_BACK
                                               : cdq_pkg::FN_PUSH_FRONT,
                          pick_value());
    send_item(cdq_pkg::FN_SHOW, '0);
    random_phase(items_sent + (ITEM_TARGET - items_sent) / 4);

    src_idle_pct   = 47;
    sink_stall_pct = 0;
    random_phase(items_sent + (ITEM_TARGET - items_sent) / 3);

    src_idle_pct   = 0;
    sink_stall_pct = 47;
    random_phase(items_sent + (ITEM_TARGET - items_sent) / 2);

    src_idle_pct   = 29;
    sink_stall_pct = 29;
    random_phase(ITEM_TARGET);

    s_axis_tvalid  <= 1'b0;
    sink_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d deque requests producing %0d result transfers.",
             sb.requests, sb.results_seen);
    $display("Overflow pushes %0d, underflow pops %0d, empty shows %0d.",
             sb.status_count[cdq_pkg::STAT_OVERFLOW],
             sb.status_count[cdq_pkg::STAT_UNDERFLOW],
             sb.status_count[cdq_pkg::STAT_EMPTY]);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
